// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HAH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HAH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/hah_pkg.sv =====
// Shared constants and types of the hot-address histogram.
package hah_pkg;

  localparam int SLOTS_DEF       = 4096;
  localparam int PROBE_LIMIT_DEF = 8;

  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 32;
  localparam int RC_W       = 6;
  localparam int OUT_DATA_W = ADDR_W + COUNT_W;

  localparam logic [RC_W-1:0]    REPORT_RESET = 6'd25;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_DUMP   = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  hot_address;
    logic [COUNT_W-1:0] hit_count;
    logic               last;
  } result_t;

endpackage

// ===== src/hah_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module hah_ram #(
  parameter int DEPTH = hah_pkg::SLOTS_DEF,
  parameter int WIDTH = hah_pkg::ENTRY_W
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/hah_ctrl.sv =====
// Sequencer: clearing pass, record probing and top-k dump scans over the slot RAM.
module hah_ctrl #(
  parameter int SLOTS       = hah_pkg::SLOTS_DEF,
  parameter int PROBE_LIMIT = hah_pkg::PROBE_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [hah_pkg::ADDR_W-1:0]  in_address,
  input  logic [hah_pkg::RC_W-1:0]    report_count,
  input  logic                        res_free,
  output logic                        res_load,
  output hah_pkg::result_t            res,
  output logic                        mem_rd_en,
  output logic [$clog2(SLOTS)-1:0]    mem_rd_addr,
  input  hah_pkg::slot_entry_t        mem_rd_data,
  output logic                        mem_wr_en,
  output logic [$clog2(SLOTS)-1:0]    mem_wr_addr,
  output hah_pkg::slot_entry_t        mem_wr_data
);
  import hah_pkg::*;

  localparam int IDXW       = $clog2(SLOTS);
  localparam int KW         = $clog2(PROBE_LIMIT + 1);
  localparam bit POW2       = (SLOTS & (SLOTS - 1)) == 0;
  localparam int HASH_BITS  = 4;
  localparam int HASH_STEPS = ADDR_W / HASH_BITS;
  localparam int HCW        = $clog2(HASH_STEPS);

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
  localparam logic [IDXW:0]   SLOTS_V  = (IDXW + 1)'(SLOTS);
  localparam logic [KW-1:0]   K_NUM    = KW'(PROBE_LIMIT);
  localparam logic [KW-1:0]   K_LAST   = KW'(PROBE_LIMIT - 1);
  localparam logic [HCW-1:0]  H_LAST   = HCW'(HASH_STEPS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]         state;
  logic [IDXW-1:0]    clr_idx;
  logic [ADDR_W-1:0]  req_addr;
  logic [IDXW-1:0]    home;
  logic [IDXW-1:0]    probe_idx;
  logic [KW-1:0]      issue_k;
  slot_entry_t        home_entry;
  logic [IDXW-1:0]    hash_rem;
  logic [ADDR_W-1:0]  hash_sh;
  logic [HCW-1:0]     hash_cnt;
  logic [RC_W-1:0]    limit;
  logic [RC_W-1:0]    n_found;
  logic [IDXW-1:0]    scan_idx;
  logic               scan_issued;
  logic [IDXW-1:0]    best_idx;
  logic [ADDR_W-1:0]  best_addr;
  logic [COUNT_W-1:0] best_count;
  logic               rd_valid;
  logic [IDXW-1:0]    rd_idx;
  logic [KW-1:0]      rd_k;

  slot_entry_t        e;
  slot_entry_t        home_now;
  logic               probe_hit;
  logic               probe_end;
  logic               scan_take;
  logic [IDXW-1:0]    cand_idx;
  logic [ADDR_W-1:0]  cand_addr;
  logic [COUNT_W-1:0] cand_count;
  logic               is_last_emit;
  logic [IDXW-1:0]    rem_v;
  logic [IDXW:0]      rem_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [IDXW-1:0] idx_inc(input logic [IDXW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    e            = mem_rd_data;
    probe_hit    = (e.count == '0) || (e.addr == req_addr);
    probe_end    = (rd_k == K_LAST);
    home_now     = (rd_k == '0) ? e : home_entry;
    scan_take    = e.count > best_count;
    cand_idx     = scan_take ? rd_idx  : best_idx;
    cand_addr    = scan_take ? e.addr  : best_addr;
    cand_count   = scan_take ? e.count : best_count;
    is_last_emit = (n_found == limit - 1'b1);

    // Residue of (address >> 2) by the slot count, HASH_BITS bits per cycle, MSB first.
    rem_v = hash_rem;
    rem_t = '0;
    for (int i = 0; i < HASH_BITS; i++) begin
      rem_t = {rem_v, hash_sh[ADDR_W-1-i]};
      if (rem_t >= SLOTS_V) begin
        rem_t = rem_t - SLOTS_V;
      end
      rem_v = rem_t[IDXW-1:0];
    end

    mem_rd_en   = 1'b0;
    mem_rd_addr = probe_idx;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_idx;
    mem_wr_data = '0;

    unique case (state)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_PROBE: begin
        mem_rd_en = (issue_k != K_NUM) && !(rd_valid && (probe_hit || probe_end));
        if (rd_valid) begin
          if (probe_hit) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_idx;
            mem_wr_data = '{addr: req_addr, count: sat_inc(e.count)};
          end else if (probe_end) begin
            // Every probe failed: bump the home slot and keep its address.
            mem_wr_en   = 1'b1;
            mem_wr_addr = home;
            mem_wr_data = '{addr: home_now.addr, count: sat_inc(home_now.count)};
          end
        end
      end
      ST_SCAN: begin
        mem_rd_en   = !scan_issued;
        mem_rd_addr = scan_idx;
      end
      ST_EMIT: begin
        if (res_free && (best_count != '0)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = best_idx;
          mem_wr_data = '{addr: best_addr, count: '0};
        end
      end
      default: begin
      end
    endcase

    res_load = (state == ST_EMIT) && res_free;
    if (best_count == '0) begin
      res = '{found: 1'b0, hot_address: '0, hit_count: '0, last: 1'b1};
    end else begin
      res = '{found: 1'b1, hot_address: best_addr, hit_count: best_count,
              last: is_last_emit};
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= mem_rd_addr;
    rd_k   <= issue_k;
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      rd_valid    <= 1'b0;
      issue_k     <= '0;
      hash_cnt    <= '0;
      n_found     <= '0;
      limit       <= '0;
      scan_idx    <= '0;
      scan_issued <= 1'b0;
      best_count  <= '0;
    end else begin
      rd_valid <= mem_rd_en;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (in_req_type == REQ_DUMP) begin
              limit       <= (report_count == '0) ? RC_W'(1) : report_count;
              n_found     <= '0;
              scan_idx    <= '0;
              scan_issued <= 1'b0;
              best_idx    <= '0;
              best_count  <= '0;
              state       <= ST_SCAN;
            end else begin
              req_addr <= in_address;
              issue_k  <= '0;
              if (POW2) begin
                home      <= in_address[2 +: IDXW];
                probe_idx <= in_address[2 +: IDXW];
                state     <= ST_PROBE;
              end else begin
                hash_rem <= '0;
                hash_sh  <= {2'b00, in_address[ADDR_W-1:2]};
                hash_cnt <= '0;
                state    <= ST_HASH;
              end
            end
          end
        end
        ST_HASH: begin
          hash_rem <= rem_v;
          hash_sh  <= {hash_sh[ADDR_W-HASH_BITS-1:0], {HASH_BITS{1'b0}}};
          hash_cnt <= hash_cnt + 1'b1;
          if (hash_cnt == H_LAST) begin
            home      <= rem_v;
            probe_idx <= rem_v;
            state     <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (mem_rd_en) begin
            probe_idx <= idx_inc(probe_idx);
            issue_k   <= issue_k + 1'b1;
          end
          if (rd_valid && (rd_k == '0)) begin
            home_entry <= e;
          end
          if (rd_valid && (probe_hit || probe_end)) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (mem_rd_en) begin
            scan_idx <= idx_inc(scan_idx);
            if (scan_idx == LAST_IDX) begin
              scan_issued <= 1'b1;
            end
          end
          if (rd_valid) begin
            best_idx   <= cand_idx;
            best_addr  <= cand_addr;
            best_count <= cand_count;
            if (rd_idx == LAST_IDX) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (res_free) begin
            if ((best_count == '0) || is_last_emit) begin
              state <= ST_IDLE;
            end else begin
              n_found     <= n_found + 1'b1;
              scan_idx    <= '0;
              scan_issued <= 1'b0;
              best_idx    <= '0;
              best_count  <= '0;
              state       <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/hot_address_histogram_top_k.sv =====
// Top level of the hot-address histogram with top-k dump.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | tdata = address, tuser = req_type
//   m_*      | out       | tdata = hot_address, hit_count; tuser = found; tlast = last
//   cfg_*    | in        | report_count, written whenever cfg_we is high
//
// A record makes one RAM read per probe, at most PROBE_LIMIT probes, after a hashing
// pass over the address when SLOTS is not a power of two.
// A dump makes one full RAM scan for each reported word.
// After reset a clearing pass over all SLOTS slots zeroes the counts; s_tready stays low.
// Results wait in an output register; the sequencer holds while that register is full.
module hot_address_histogram_top_k #(
  parameter int SLOTS       = hah_pkg::SLOTS_DEF,
  parameter int PROBE_LIMIT = hah_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hah_pkg::ADDR_W-1:0]    s_tdata,   // [63:0] address
  input  logic                          s_tuser,   // [0] req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hah_pkg::OUT_DATA_W-1:0] m_tdata,  // [63:0] hot_address, [95:64] hit_count
  output logic                          m_tuser,   // [0] found
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [hah_pkg::RC_W-1:0]      cfg_wdata
);
  import hah_pkg::*;

  localparam int IDXW = $clog2(SLOTS);

  logic [RC_W-1:0] report_count;
  logic            res_free;
  logic            res_load;
  result_t         res;
  logic            mem_rd_en;
  logic [IDXW-1:0] mem_rd_addr;
  slot_entry_t     mem_rd_data;
  logic            mem_wr_en;
  logic [IDXW-1:0] mem_wr_addr;
  slot_entry_t     mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_count <= REPORT_RESET;
    end else if (cfg_we) begin
      report_count <= cfg_wdata;
    end
  end

  assign res_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_load) begin
      m_tdata <= {res.hit_count, res.hot_address};
      m_tuser <= res.found;
      m_tlast <= res.last;
    end
  end

  hah_ctrl #(
    .SLOTS       (SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_req_type  (s_tuser),
    .in_address   (s_tdata),
    .report_count (report_count),
    .res_free     (res_free),
    .res_load     (res_load),
    .res          (res),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data)
  );

  hah_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

// ===== src/hah_checker.sv =====
// Port-level checker for the hot-address histogram, bound to the top level.
`include "assert_macros.svh"

module hah_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hah_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import hah_pkg::*;

  logic [COUNT_W-1:0]    out_count;
  logic [OUT_DATA_W+1:0] out_word;

  assign out_count = m_tdata[OUT_DATA_W-1:ADDR_W];
  assign out_word  = {m_tlast, m_tuser, m_tdata};

  // A stalled result word holds its contents.
  `HAH_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // The block works on one request at a time.
  `HAH_ASSERT_NXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // The clearing pass keeps the input closed right after reset.
  `HAH_ASSERT_NXT(a_clear_after_reset, clk, 1'b0, rst, !s_tready)

  // An exhausted-table word is the final one of its dump and carries zeros.
  `HAH_ASSERT_IMP(a_empty_word, clk, rst, m_tvalid && !m_tuser, m_tlast && (m_tdata == '0))

  // A reported entry never has a zero count.
  `HAH_ASSERT_IMP(a_found_nonzero, clk, rst, m_tvalid && m_tuser, out_count != '0)

endmodule

bind hot_address_histogram_top_k hah_checker u_hah_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== test/hot_address_histogram_top_k_tb.sv =====
// Testbench for the hot-address histogram: directed and random requests checked against a table model.
module hot_address_histogram_top_k_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hah_pkg::*;

  localparam int TBL_SLOTS = SLOTS_DEF;
  localparam int PROBES = PROBE_LIMIT_DEF;
  // A settling wait, sized from PROBES, lets a record finish before the register is touched.
  localparam int SETTLE_CYCLES = 2 * (PROBES + 2);

  // Tracks the table contents and the report words each dump should return.
  class hot_report_tracker;
    logic [ADDR_W-1:0]  tbl_addr  [TBL_SLOTS];
    logic [COUNT_W-1:0] tbl_count [TBL_SLOTS];
    logic [RC_W-1:0]    top_k;
    result_t            pending_reports [$];
    int                 failures;
    int                 records;
    int                 dumps;
    int                 words;

    function new();
      foreach (tbl_addr[j]) begin
        tbl_addr[j] = '0;
        tbl_count[j] = '0;
      end
      top_k = REPORT_RESET;
      failures = 0;
      records = 0;
      dumps = 0;
      words = 0;
    endfunction

    function void set_top_k(logic [RC_W-1:0] value);
      top_k = value;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void take_request(logic req, logic [ADDR_W-1:0] addr);
      int unsigned home;
      int unsigned j;
      int unsigned best;
      int unsigned limit;
      logic [COUNT_W-1:0] best_count;
      result_t r;
      bit placed;
      if (req == REQ_RECORD) begin
        records++;
        home = (addr >> 2) % TBL_SLOTS;
        placed = 0;
        for (int k = 0; k < PROBES && !placed; k++) begin
          j = (home + k) % TBL_SLOTS;
          if (tbl_count[j] == 0 || tbl_addr[j] == addr) begin
            tbl_addr[j] = addr;
            if (tbl_count[j] != COUNT_MAX) tbl_count[j]++;
            placed = 1;
          end
        end
        // Every probe was taken by another address: the home slot absorbs the hit.
        if (!placed && tbl_count[home] != COUNT_MAX) tbl_count[home]++;
        return;
      end
      dumps++;
      limit = (top_k == 0) ? 1 : top_k;
      for (int n = 0; n < limit; n++) begin
        best = 0;
        best_count = '0;
        for (int s = 0; s < TBL_SLOTS; s++) begin
          if (tbl_count[s] > best_count) begin
            best_count = tbl_count[s];
            best = s;
          end
        end
        if (best_count == 0) begin
          r = '0;
          r.last = 1'b1;
          pending_reports.push_back(r);
          return;
        end
        r.found = 1'b1;
        r.hot_address = tbl_addr[best];
        r.hit_count = best_count;
        r.last = (n + 1 == limit);
        pending_reports.push_back(r);
        tbl_count[best] = '0;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      words++;
      if (pending_reports.size() == 0) begin
        flag($sformatf("%0t: unexpected report word found=%0b addr=%h count=%0d last=%0b",
                       $time, got.found, got.hot_address, got.hit_count, got.last));
        return;
      end
      want = pending_reports.pop_front();
      if (got.found !== want.found || got.hot_address !== want.hot_address ||
          got.hit_count !== want.hit_count || got.last !== want.last) begin
        flag($sformatf({"%0t: report word %0d mismatch: expected found=%0b addr=%h count=%0d ",
                        "last=%0b, got found=%0b addr=%h count=%0d last=%0b"},
                       $time, words, want.found, want.hot_address, want.hit_count, want.last,
                       got.found, got.hot_address, got.hit_count, got.last));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [ADDR_W-1:0]     s_tdata;    // [63:0] address
  logic                  s_tuser;    // [0] req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // [63:0] hot_address, [95:64] hit_count
  logic                  m_tuser;    // [0] found
  logic                  m_tlast;
  logic                  cfg_we;
  logic [RC_W-1:0]       cfg_wdata;

  hot_report_tracker tracker = new();
  bit tx_calm;
  bit rx_calm;
  int cfg_writes;

  hot_address_histogram_top_k i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are observed here, on pre-edge values.
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.found = m_tuser;
        got.hot_address = m_tdata[ADDR_W-1:0];
        got.hit_count = m_tdata[OUT_DATA_W-1:ADDR_W];
        got.last = m_tlast;
        tracker.check_report(got);
      end
    end
  end

  // Result side: a random stall before each word unless the phase runs calm.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken, valid still high.
  task automatic issue_request(logic req, logic [ADDR_W-1:0] addr);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = req;
    s_tdata = addr;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // The register is only written once all reports are in and a record has had time to finish.
  task automatic write_report_count(logic [RC_W-1:0] value);
    s_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_top_k(value);
    cfg_writes++;
  endtask

  initial begin
    logic [ADDR_W-1:0] hot_pool [24];
    int unsigned pool_homes [4];
    int dumps_left;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_RECORD;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    cfg_writes = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed part, starting with the reset value of report_count on an empty table.
    issue_request(REQ_DUMP, '0);
    issue_request(REQ_RECORD, 64'h0);
    issue_request(REQ_RECORD, '1);
    issue_request(REQ_RECORD, '1);
    // Seven more addresses homed at the last slot: the probe wraps to slot 0,
    // fills slots 1 to 6, and the seventh finds no free slot at all.
    for (int i = 1; i <= 7; i++) issue_request(REQ_RECORD, (64'(i) << 40) | 64'h3FFF);
    issue_request(REQ_RECORD, (64'(3) << 40) | 64'h3FFF);
    write_report_count(6'd1);
    issue_request(REQ_DUMP, '1);
    write_report_count(6'd0);
    issue_request(REQ_DUMP, '0);
    // Only equal counts remain, so the lowest slots come first and the table runs dry.
    write_report_count(6'd63);
    issue_request(REQ_DUMP, '0);
    issue_request(REQ_RECORD, 64'h8000_0000_0000_0000);
    issue_request(REQ_RECORD, 64'h5555_5555_5555_5555);
    issue_request(REQ_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_request(REQ_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    write_report_count(6'd2);
    issue_request(REQ_DUMP, '0);

    // A pool of addresses clustered on a few home slots keeps collisions, matches
    // and exhausted probes frequent; fully random addresses fill the rest.
    pool_homes = '{TBL_SLOTS - 1, 100, 104, 2000};
    foreach (hot_pool[i]) begin
      hot_pool[i] = ({$urandom, $urandom} & ~64'h3FFC) | (64'(pool_homes[i % 4]) << 2);
    end
    dumps_left = 12;
    for (int phase = 0; phase < 8; phase++) begin
      write_report_count(6'($urandom_range(1, 6)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 42; i++) begin
        if (dumps_left > 0 && $urandom_range(0, 15) == 0) begin
          issue_request(REQ_DUMP, {$urandom, $urandom});
          dumps_left--;
        end else if ($urandom_range(0, 9) < 6) begin
          issue_request(REQ_RECORD, hot_pool[$urandom_range(0, 23)]);
        end else begin
          issue_request(REQ_RECORD, {$urandom, $urandom});
        end
      end
      issue_request(REQ_DUMP, {$urandom, $urandom});
    end

    s_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Covered %0d record and %0d dump requests, %0d report words checked,",
             tracker.records, tracker.dumps, tracker.words);
    $display("over %0d report_count writes including 0, 1 and 63; %0d failures.",
             cfg_writes, tracker.failures);
    if (tracker.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Each dump word costs a full table scan; this bound covers the worst case several times.
  initial begin
    repeat (8) #50_000_000;
    $display("Timeout with %0d report words still outstanding.", tracker.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hah_pkg.sv
src/hah_ram.sv
src/hah_ctrl.sv
src/hot_address_histogram_top_k.sv
src/hah_checker.sv
test/hot_address_histogram_top_k_tb.sv
